@@ sv/gsh_pkg.sv @@
package gsh_pkg;

	localparam int COORD_W = 16;
	localparam int CELL_W = 8;
	localparam int SIZE_W = 13;
	localparam int ID_W = 5;
	localparam int MASK_W = 32;
	localparam int DIV_STEPS = COORD_W;
	localparam int DEF_GRID_COLS = 64;
	localparam int DEF_GRID_ROWS = 64;
	localparam int DEF_MAX_OBJECTS = 32;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_SEARCH  = 2'd2,
		CMD_COLLIDE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_SAME    = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_WORLD_W = 2'd0,
		CFG_WORLD_H = 2'd1,
		CFG_CELL_W  = 2'd2,
		CFG_CELL_H  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CELL_W-1:0] sx;
		logic [CELL_W-1:0] sy;
		logic [CELL_W-1:0] ex;
		logic [CELL_W-1:0] ey;
	} range_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] id;
		logic            outside;
		range_t          rng;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} qctl_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_DEC,
		B_CHK,
		B_RD,
		B_MOD,
		B_FIN
	} back_state_t;

	typedef enum logic [1:0] {
		WK_CLR,
		WK_SET,
		WK_OR,
		WK_CNT
	} walk_op_t;

	// One restoring division step: remainder in the upper bits, quotient below.
	function automatic logic [SIZE_W+COORD_W-1:0] div_step(
		input logic [SIZE_W-1:0]  rem,
		input logic [COORD_W-1:0] quo,
		input logic [SIZE_W-1:0]  dvs
	);
		logic [SIZE_W:0] t;
		logic [SIZE_W:0] d;
		begin
			t = {rem, quo[COORD_W-1]};
			d = {1'b0, dvs};
			if (t >= d) begin
				t = t - d;
				div_step = {t[SIZE_W-1:0], quo[COORD_W-2:0], 1'b1};
			end else begin
				div_step = {t[SIZE_W-1:0], quo[COORD_W-2:0], 1'b0};
			end
		end
	endfunction

	function automatic logic [CELL_W-1:0] clamp_cell(
		input logic [COORD_W-1:0] q,
		input logic [CELL_W-1:0]  last
	);
		begin
			if (q > COORD_W'(last))
				clamp_cell = last;
			else
				clamp_cell = q[CELL_W-1:0];
		end
	endfunction

endpackage

@@ sv/gsh_front.sv @@
module gsh_front #(
	parameter int GRID_COLS = gsh_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS = gsh_pkg::DEF_GRID_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         enable,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [gsh_pkg::ID_W-1:0]     obj_id,
	input  logic [gsh_pkg::COORD_W-1:0]  left_x,
	input  logic [gsh_pkg::COORD_W-1:0]  top_y,
	input  logic [gsh_pkg::COORD_W-1:0]  right_x,
	input  logic [gsh_pkg::COORD_W-1:0]  bottom_y,
	input  logic [gsh_pkg::COORD_W-1:0]  world_width,
	input  logic [gsh_pkg::COORD_W-1:0]  world_height,
	input  logic [gsh_pkg::SIZE_W-1:0]   cell_width,
	input  logic [gsh_pkg::SIZE_W-1:0]   cell_height,
	input  logic                         q_full,
	output logic                         push,
	output gsh_pkg::job_t                push_job
);
	import gsh_pkg::*;

	localparam logic [CELL_W-1:0] LAST_COL = CELL_W'(GRID_COLS - 1);
	localparam logic [CELL_W-1:0] LAST_ROW = CELL_W'(GRID_ROWS - 1);

	front_state_t state_q, state_d;
	logic [$clog2(DIV_STEPS)-1:0] step_q;
	logic [SIZE_W-1:0]  rem_q [4];
	logic [COORD_W-1:0] quo_q [4];
	logic [SIZE_W-1:0]  dvs_x_q, dvs_y_q;
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic               outside_q;
	logic               accept;

	assign in_ready = (state_q == F_IDLE) && enable;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_DIV;
			F_DIV:  if (step_q == '1) state_d = F_PUSH;
			F_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_DIV)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	// Lanes 0 and 2 divide by the cell width, lanes 1 and 3 by the cell height.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(cmd);
			id_q      <= obj_id;
			outside_q <= (right_x > world_width) || (bottom_y > world_height);
			dvs_x_q   <= (cell_width == '0) ? SIZE_W'(1) : cell_width;
			dvs_y_q   <= (cell_height == '0) ? SIZE_W'(1) : cell_height;
			quo_q[0]  <= left_x;
			quo_q[1]  <= top_y;
			quo_q[2]  <= right_x;
			quo_q[3]  <= bottom_y;
			for (int i = 0; i < 4; i++)
				rem_q[i] <= '0;
		end else if (state_q == F_DIV) begin
			for (int i = 0; i < 4; i++)
				{rem_q[i], quo_q[i]} <= div_step(rem_q[i], quo_q[i],
					(i % 2 == 0) ? dvs_x_q : dvs_y_q);
		end
	end

	always_comb begin
		push_job.cmd     = cmd_q;
		push_job.id      = id_q;
		push_job.outside = outside_q;
		push_job.rng.sx  = clamp_cell(quo_q[0], LAST_COL);
		push_job.rng.sy  = clamp_cell(quo_q[1], LAST_ROW);
		push_job.rng.ex  = clamp_cell(quo_q[2], LAST_COL);
		push_job.rng.ey  = clamp_cell(quo_q[3], LAST_ROW);
	end

endmodule

@@ sv/gsh_queue.sv @@
module gsh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  gsh_pkg::job_t wr_job,
	output gsh_pkg::job_t rd_job,
	input  gsh_pkg::qctl_t ctl_in,
	output gsh_pkg::qctl_t ctl_out
);
	import gsh_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign rd_job        = mem_q[rp_q];
	assign ctl_out.push  = ctl_in.push;
	assign ctl_out.pop   = ctl_in.pop;
	assign ctl_out.full  = (cnt_q == 2'd2);
	assign ctl_out.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ctl_in.push) wp_q <= ~wp_q;
			if (ctl_in.pop)  rp_q <= ~rp_q;
			if (ctl_in.push && !ctl_in.pop)
				cnt_q <= cnt_q + 1'b1;
			else if (ctl_in.pop && !ctl_in.push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.push) mem_q[wp_q] <= wr_job;
	end

endmodule

@@ sv/gsh_back.sv @@
module gsh_back #(
	parameter int GRID_COLS   = gsh_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS   = gsh_pkg::DEF_GRID_ROWS,
	parameter int MAX_OBJECTS = gsh_pkg::DEF_MAX_OBJECTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  gsh_pkg::job_t               job,
	output logic                        pop,
	output logic                        ready_for_items,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        hit,
	output logic [gsh_pkg::MASK_W-1:0]  found_mask
);
	import gsh_pkg::*;

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam int NIDS = 1 << ID_W;

	back_state_t       state_q, state_d;
	logic [AW-1:0]     clr_q;
	job_t              job_q;
	walk_op_t          op_q;
	range_t            wr_q;
	logic [CELL_W-1:0] x_q, y_q;
	logic [MASK_W-1:0] acc_q;
	logic [1:0]        cnt_q;
	range_t            ranges_q [NIDS];
	logic [NIDS-1:0]   present_q;
	logic              out_valid_q;
	status_t           status_q;
	logic              hit_q;
	logic [MASK_W-1:0] found_q;

	logic [MASK_W-1:0] mem [DEPTH];
	logic [MASK_W-1:0] rdata_q;
	logic [AW-1:0]     cell_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [MASK_W-1:0] mem_wdata;

	logic [MASK_W-1:0] bit_sel;
	logic              id_ok, is_present, same_rng, walk_empty, last_cell, phase_end;
	logic              to_set_phase;
	range_t            old_rng;
	logic [6:0]        cnt_sum;

	assign cell_addr  = AW'(y_q) * AW'(GRID_COLS) + AW'(x_q);
	assign bit_sel    = MASK_W'(1) << job_q.id;
	assign id_ok      = {2'b00, job_q.id} < 7'(MAX_OBJECTS);
	assign is_present = present_q[job_q.id];
	assign old_rng    = ranges_q[job_q.id];
	assign same_rng   = (old_rng == job_q.rng);
	assign walk_empty = (wr_q.sx > wr_q.ex) || (wr_q.sy > wr_q.ey);
	assign last_cell  = (x_q == wr_q.ex) && (y_q == wr_q.ey);
	assign phase_end  = ((state_q == B_CHK) && walk_empty) ||
		((state_q == B_MOD) && last_cell);
	// Only a moving insert goes on from clearing the old cells to marking new ones.
	assign to_set_phase = phase_end && (op_q == WK_CLR) && (job_q.cmd == CMD_INSERT);
	assign cnt_sum    = 7'(cnt_q) + 7'($countones(rdata_q));

	assign ready_for_items = (state_q != B_CLEAR);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign hit        = hit_q;
	assign found_mask = found_q;
	assign pop        = (state_q == B_IDLE) && !q_empty && !out_valid_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr;
		mem_wdata = rdata_q;
		if (state_q == B_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == B_MOD && op_q == WK_SET) begin
			mem_we    = 1'b1;
			mem_wdata = rdata_q | bit_sel;
		end else if (state_q == B_MOD && op_q == WK_CLR) begin
			mem_we    = 1'b1;
			mem_wdata = rdata_q & ~bit_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[cell_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = B_IDLE;
			B_IDLE:  if (pop) state_d = B_DEC;
			B_DEC: begin
				priority case (job_q.cmd)
					CMD_INSERT: begin
						if (job_q.outside || !id_ok || (is_present && same_rng))
							state_d = B_IDLE;
						else
							state_d = B_CHK;
					end
					CMD_REMOVE: state_d = (id_ok && is_present) ? B_CHK : B_IDLE;
					CMD_SEARCH: state_d = job_q.outside ? B_IDLE : B_CHK;
					default:    state_d = B_CHK;
				endcase
			end
			B_CHK, B_MOD: begin
				if (phase_end)
					state_d = (op_q == WK_CLR && job_q.cmd == CMD_INSERT) ? B_CHK : B_FIN;
				else if (state_q == B_CHK || !last_cell)
					state_d = B_RD;
			end
			B_RD:   state_d = B_MOD;
			B_FIN:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			present_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == B_DEC && state_d == B_IDLE) out_valid_q <= 1'b1;
			if (state_q == B_FIN) begin
				out_valid_q <= 1'b1;
				if (job_q.cmd == CMD_INSERT) present_q[job_q.id] <= 1'b1;
				if (job_q.cmd == CMD_REMOVE) present_q[job_q.id] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NIDS; i++)
				ranges_q[i] <= '0;
		end else if (state_q == B_FIN) begin
			if (job_q.cmd == CMD_INSERT) ranges_q[job_q.id] <= job_q.rng;
			if (job_q.cmd == CMD_REMOVE) ranges_q[job_q.id] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		unique case (state_q)
			B_DEC: begin
				acc_q   <= '0;
				cnt_q   <= '0;
				hit_q   <= 1'b0;
				found_q <= '0;
				priority case (job_q.cmd)
					CMD_INSERT: begin
						if (job_q.outside)
							status_q <= ST_OUTSIDE;
						else if (!id_ok)
							status_q <= ST_ABSENT;
						else if (is_present && same_rng)
							status_q <= ST_SAME;
						else
							status_q <= ST_DONE;
						op_q <= is_present ? WK_CLR : WK_SET;
						wr_q <= is_present ? old_rng : job_q.rng;
					end
					CMD_REMOVE: begin
						status_q <= (!id_ok || !is_present) ? ST_ABSENT : ST_DONE;
						op_q     <= WK_CLR;
						wr_q     <= old_rng;
					end
					CMD_SEARCH: begin
						status_q <= job_q.outside ? ST_OUTSIDE : ST_DONE;
						op_q     <= WK_OR;
						wr_q     <= job_q.rng;
					end
					default: begin
						status_q <= ST_DONE;
						op_q     <= WK_CNT;
						wr_q     <= job_q.rng;
					end
				endcase
			end
			B_CHK: begin
				x_q <= wr_q.sx;
				y_q <= wr_q.sy;
				if (to_set_phase) begin
					op_q <= WK_SET;
					wr_q <= job_q.rng;
				end
			end
			B_MOD: begin
				if (op_q == WK_OR) acc_q <= acc_q | rdata_q;
				if (op_q == WK_CNT) cnt_q <= (cnt_sum > 7'd1) ? 2'd2 : cnt_sum[1:0];
				if (to_set_phase) begin
					op_q <= WK_SET;
					wr_q <= job_q.rng;
				end
				if (!phase_end) begin
					if (x_q == wr_q.ex) begin
						x_q <= wr_q.sx;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
			end
			B_FIN: begin
				status_q <= ST_DONE;
				hit_q    <= (op_q == WK_CNT) && (cnt_q == 2'd2);
				found_q  <= (op_q == WK_OR) ? acc_q : '0;
			end
			default: ;
		endcase
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE) && !out_valid_q)
		else $error("job taken while back end busy");

	a_write_needs_op: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != B_CLEAR) |-> (op_q == WK_SET || op_q == WK_CLR))
		else $error("cell write during a read-only walk");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_CLEAR) |=> (state_q != B_CLEAR))
		else $error("clearing pass re-entered");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MOD) |-> (cnt_q != 2'd3))
		else $error("occupancy count escaped saturation");

endmodule

@@ sv/grid_spatial_hash_core.sv @@
// Uniform-grid spatial hash. Each cell of a GRID_COLS x GRID_ROWS grid holds
// a 32-bit mask of the object ids overlapping it; commands insert, remove,
// search and collision-test integer rectangles, and each command yields
// exactly one result transfer. After reset the cell memory is swept to zero,
// one cell a cycle, all GRID_COLS*GRID_ROWS cells (4096 at the defaults);
// input transfers are held off until it finishes, while configuration
// writes are taken throughout. The front end takes one command at a time
// and maps its edges to cells with four radix-2 dividers (one quotient bit
// per cycle), then hands it to a two-entry queue, waiting while the queue
// is full; it takes no new command until the job is pushed. The back end
// does the work on the cell memory, reading each covered cell and then
// modifying it or accumulating from it; a moving insert walks the old and
// the new range. Commands that are rejected finish without walking any
// cells. Because the front end divides the next command while the back end
// walks, the sustained rate is set by the slower of the two.
// Configuration must only be written while the block is idle.
module grid_spatial_hash_core #(
	parameter int GRID_COLS   = gsh_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS   = gsh_pkg::DEF_GRID_ROWS,
	parameter int MAX_OBJECTS = gsh_pkg::DEF_MAX_OBJECTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [gsh_pkg::ID_W-1:0]    obj_id,
	input  logic [gsh_pkg::COORD_W-1:0] left_x,
	input  logic [gsh_pkg::COORD_W-1:0] top_y,
	input  logic [gsh_pkg::COORD_W-1:0] right_x,
	input  logic [gsh_pkg::COORD_W-1:0] bottom_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        hit,
	output logic [gsh_pkg::MASK_W-1:0]  found_mask
);
	import gsh_pkg::*;

	logic [COORD_W-1:0] world_w_q, world_h_q;
	logic [SIZE_W-1:0]  cell_w_q, cell_h_q;
	logic               back_ready;
	qctl_t              qctl, qstat;
	job_t               push_job, head_job;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q <= COORD_W'(2048);
			world_h_q <= COORD_W'(2048);
			cell_w_q  <= SIZE_W'(32);
			cell_h_q  <= SIZE_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WORLD_W: world_w_q <= cfg_data;
				CFG_WORLD_H: world_h_q <= cfg_data;
				CFG_CELL_W:  cell_w_q  <= cfg_data[SIZE_W-1:0];
				CFG_CELL_H:  cell_h_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: takes a command, divides its edges into cell indices and
	// checks the world bounds, then pushes a job into the queue.
	gsh_front #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable      (back_ready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.obj_id      (obj_id),
		.left_x      (left_x),
		.top_y       (top_y),
		.right_x     (right_x),
		.bottom_y    (bottom_y),
		.world_width (world_w_q),
		.world_height(world_h_q),
		.cell_width  (cell_w_q),
		.cell_height (cell_h_q),
		.q_full      (qstat.full),
		.push        (qctl.push),
		.push_job    (push_job)
	);

	assign qctl.full  = 1'b0;
	assign qctl.empty = 1'b0;

	gsh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (push_job),
		.rd_job (head_job),
		.ctl_in (qctl),
		.ctl_out(qstat)
	);

	// Back end: owns the cell memory and the object table, walks the
	// covered cells and drives the registered result.
	gsh_back #(
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS),
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (qstat.empty),
		.job            (head_job),
		.pop            (qctl.pop),
		.ready_for_items(back_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.hit            (hit),
		.found_mask     (found_mask)
	);

endmodule
